@@ design/decimal_text_to_scaled_integer_top_macros.svh @@
// assertion macros for the decimal text to scaled integer block
// used by the port checker; no other dependencies
`ifndef DECIMAL_TEXT_TO_SCALED_INTEGER_TOP_MACROS_SVH
`define DECIMAL_TEXT_TO_SCALED_INTEGER_TOP_MACROS_SVH

// checked only while out of reset
`define DTSI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked at every edge, reset included
`define DTSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/dtsi_pkg.sv @@
// shared types, constants and arithmetic helpers for the decimal text parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dtsi_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned WHOLE_W = 64;
  localparam int unsigned FRAC_W  = 60;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned POW_W   = 60;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd8;
  // largest power of ten that stays below 2^63
  localparam logic [SCALE_W-1:0] POW_MAX_EXP = 5'd18;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [0:0]         REG_IDX_SCALE = 1'b0;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_POINT = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_MALFORMED = 3'd2,
    ERR_BAD_WHOLE = 3'd3,
    ERR_BAD_FRAC  = 3'd4,
    ERR_OVERFLOW  = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WHOLE = 2'd1,
    PH_FRAC  = 2'd2
  } phase_e;

  // parse state of one text, also the snapshot handed to the result pipeline
  typedef struct packed {
    logic               neg;
    phase_e             phase;
    logic               whole_seen;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [COUNT_W-1:0] count;
    err_e               pending;
  } text_t;

  // partial products of a 64 x 60 multiply split at bit 32
  typedef struct packed {
    logic [63:0] ll;
    logic [59:0] lh;
    logic [63:0] hl;
    logic        hh_nz;
  } part_t;

  function automatic logic [POW_W-1:0] pow10(input logic [SCALE_W-1:0] e);
    logic [POW_W-1:0] p;
    case (e)
      5'd0:    p = 60'd1;
      5'd1:    p = 60'd10;
      5'd2:    p = 60'd100;
      5'd3:    p = 60'd1000;
      5'd4:    p = 60'd10000;
      5'd5:    p = 60'd100000;
      5'd6:    p = 60'd1000000;
      5'd7:    p = 60'd10000000;
      5'd8:    p = 60'd100000000;
      5'd9:    p = 60'd1000000000;
      5'd10:   p = 60'd10000000000;
      5'd11:   p = 60'd100000000000;
      5'd12:   p = 60'd1000000000000;
      5'd13:   p = 60'd10000000000000;
      5'd14:   p = 60'd100000000000000;
      5'd15:   p = 60'd1000000000000000;
      5'd16:   p = 60'd10000000000000000;
      5'd17:   p = 60'd100000000000000000;
      5'd18:   p = 60'd1000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic part_t part_mul(input logic [63:0] x, input logic [59:0] y);
    part_t r;
    r.ll    = 64'(x[31:0]) * 64'(y[31:0]);
    r.lh    = 60'(x[31:0]) * 60'(y[59:32]);
    r.hl    = 64'(x[63:32]) * 64'(y[31:0]);
    r.hh_nz = (x[63:32] != '0) && (y[59:32] != '0);
    return r;
  endfunction

  // returns {overflow above 2^63-1, low 63 bits of the product}
  function automatic logic [63:0] part_sum(input part_t m);
    logic [96:0] t;
    t = {33'b0, m.ll} + {5'b0, m.lh, 32'b0} + {1'b0, m.hl, 32'b0};
    return {m.hh_nz | (|t[96:63]), t[62:0]};
  endfunction

endpackage

@@ design/dtsi_parse.sv @@
// character parser: sign, whole and fraction accumulators, pending error
// depends on dtsi_pkg
`timescale 1ns / 1ps

module dtsi_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     char_code_i,
  input  logic           has_char_i,
  input  logic           last_char_i,
  output dtsi_pkg::text_t text_o
);
  import dtsi_pkg::*;

  text_t       st_q, st_d;
  logic        is_digit, is_sign, is_point;
  logic [3:0]  digit;
  logic [67:0] whole_next;
  logic [63:0] frac_next;
  logic        whole_ovf, frac_ovf;

  function automatic err_e note(input err_e cur, input err_e code);
    return ((cur == ERR_NONE) || (code < cur)) ? code : cur;
  endfunction

  always_comb begin
    is_digit = char_code_i inside {[CHAR_ZERO:CHAR_NINE]};
    is_sign  = char_code_i inside {CHAR_MINUS, CHAR_PLUS};
    is_point = (char_code_i == CHAR_POINT);
    digit    = 4'(char_code_i - CHAR_ZERO);
    // times ten as two shifts plus the new digit
    whole_next = {1'b0, st_q.whole, 3'b0} + {3'b0, st_q.whole, 1'b0} + {64'b0, digit};
    frac_next  = {1'b0, st_q.frac, 3'b0} + {3'b0, st_q.frac, 1'b0} + {60'b0, digit};
    whole_ovf  = |whole_next[67:64];
    frac_ovf   = |frac_next[63:60];
  end

  always_comb begin
    st_d = st_q;
    if (has_char_i) begin
      if ((st_q.phase == PH_START) && is_sign) begin
        st_d.phase = PH_WHOLE;
        st_d.neg   = (char_code_i == CHAR_MINUS);
      end else if (st_q.phase != PH_FRAC) begin
        if (is_point) begin
          st_d.phase = PH_FRAC;
        end else begin
          st_d.phase      = PH_WHOLE;
          st_d.whole_seen = 1'b1;
          if (is_digit && !whole_ovf) begin
            st_d.whole = whole_next[63:0];
          end else begin
            st_d.pending = note(st_q.pending, ERR_BAD_WHOLE);
          end
        end
      end else begin
        if (st_q.count != COUNT_MAX) begin
          st_d.count = st_q.count + COUNT_W'(1);
        end
        if (is_digit && !frac_ovf) begin
          st_d.frac = frac_next[59:0];
        end else begin
          st_d.pending = note(st_q.pending, ERR_BAD_FRAC);
        end
      end
    end
  end

  assign text_o = st_d;

  // the last transfer hands the text on and starts a fresh one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (take_i) begin
      if (last_char_i) begin
        st_q <= '0;
      end else begin
        st_q <= st_d;
      end
    end
  end

endmodule

@@ design/dtsi_finish.sv @@
// result pipeline: error ranking, scale multiply, overflow check, sign, output register
// depends on dtsi_pkg
`timescale 1ns / 1ps

module dtsi_finish (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dtsi_pkg::SCALE_W-1:0]  scale_i,
  input  logic                          snap_valid_i,
  input  dtsi_pkg::text_t               snap_i,
  output logic                          ready_o,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [dtsi_pkg::VALUE_W-1:0]  scaled_value_o,
  output dtsi_pkg::err_e                result_code_o
);
  import dtsi_pkg::*;

  typedef struct packed {
    logic               neg;
    err_e               code;
    logic               pre_ovf;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [POW_W-1:0]   p;
    logic [POW_W-1:0]   q;
  } pow_t;

  typedef struct packed {
    logic  neg;
    err_e  code;
    logic  pre_ovf;
    part_t wm;
    part_t fm;
  } mul_t;

  typedef struct packed {
    logic        neg;
    err_e        code;
    logic        ovf;
    logic [62:0] a;
    logic [62:0] b;
  } sum_t;

  typedef struct packed {
    logic        neg;
    err_e        code;
    logic [62:0] mag;
  } mag_t;

  logic   v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic   rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
  text_t  t1_q;
  pow_t   s2_q, s2_d;
  mul_t   s3_q, s3_d;
  sum_t   s4_q, s4_d;
  mag_t   s5_q, s5_d;
  logic [SCALE_W-1:0] frac_exp;
  logic [63:0]        a_res, b_res;
  logic [63:0]        mag_sum;
  logic [VALUE_W-1:0] value_q, value_d;
  err_e               code_q;

  // each stage moves on when it is empty or its successor moves on
  assign rdy_out = !vo_q || !stall_i;
  assign rdy5    = !v5_q || rdy_out;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // error ranking and power of ten lookup
  always_comb begin
    frac_exp     = scale_i - t1_q.count;
    s2_d.neg     = t1_q.neg;
    s2_d.whole   = t1_q.whole;
    s2_d.frac    = t1_q.frac;
    s2_d.p       = pow10(scale_i);
    s2_d.q       = pow10(frac_exp);
    s2_d.pre_ovf = ((scale_i > POW_MAX_EXP) && (t1_q.whole != '0)) ||
                   ((frac_exp > POW_MAX_EXP) && (t1_q.frac != '0));
    if (t1_q.phase == PH_START) begin
      s2_d.code = ERR_EMPTY;
    end else if (!t1_q.whole_seen || (t1_q.count > scale_i)) begin
      s2_d.code = ERR_MALFORMED;
    end else begin
      s2_d.code = t1_q.pending;
    end
  end

  always_comb begin
    s3_d.neg     = s2_q.neg;
    s3_d.code    = s2_q.code;
    s3_d.pre_ovf = s2_q.pre_ovf;
    s3_d.wm      = part_mul(s2_q.whole, s2_q.p);
    s3_d.fm      = part_mul({4'b0, s2_q.frac}, s2_q.q);
  end

  always_comb begin
    a_res     = part_sum(s3_q.wm);
    b_res     = part_sum(s3_q.fm);
    s4_d.neg  = s3_q.neg;
    s4_d.code = s3_q.code;
    s4_d.ovf  = s3_q.pre_ovf | a_res[63] | b_res[63];
    s4_d.a    = a_res[62:0];
    s4_d.b    = b_res[62:0];
  end

  always_comb begin
    mag_sum  = {1'b0, s4_q.a} + {1'b0, s4_q.b};
    s5_d.neg = s4_q.neg;
    s5_d.mag = mag_sum[62:0];
    if (s4_q.code != ERR_NONE) begin
      s5_d.code = s4_q.code;
    end else if (s4_q.ovf || mag_sum[63]) begin
      s5_d.code = ERR_OVERFLOW;
    end else begin
      s5_d.code = ERR_NONE;
    end
  end

  always_comb begin
    if (s5_q.code != ERR_NONE) begin
      value_d = '0;
    end else if (s5_q.neg) begin
      value_d = VALUE_W'(0) - {1'b0, s5_q.mag};
    end else begin
      value_d = {1'b0, s5_q.mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= snap_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
      if (rdy_out) begin
        vo_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && snap_valid_i) begin
      t1_q <= snap_i;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
    if (rdy4 && v3_q) begin
      s4_q <= s4_d;
    end
    if (rdy5 && v4_q) begin
      s5_q <= s5_d;
    end
    if (rdy_out && v5_q) begin
      value_q <= value_d;
      code_q  <= s5_q.code;
    end
  end

  assign valid_o        = vo_q;
  assign scaled_value_o = value_q;
  assign result_code_o  = code_q;

endmodule

@@ design/decimal_text_to_scaled_integer_top.sv @@
// top level of the decimal text to scaled integer converter
// depends on dtsi_pkg, dtsi_parse and dtsi_finish
//
// channel   direction  handshake          payload
// input     in         valid_i / stall_o  char_code_i, has_char_i, last_char_i
// result    out        valid_o / stall_i  scaled_value_o, result_code_o
// config    in         apb write/read     decimal_scale at byte address 0
//
// one transfer per cycle unless stalled; the accumulators update in that cycle
// the result shows on valid_o once the text of the last item has passed the six
// register stages of the scale multiply and sign handling
// stall_o rises only when all six result stages hold results under stall
// reset clears the text state and the pipeline and sets the scale to 8
`timescale 1ns / 1ps

module decimal_text_to_scaled_integer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          has_char_i,
  input  logic                          last_char_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [63:0]                   scaled_value_o,
  output logic [2:0]                    result_code_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtsi_pkg::PADDR_W-1:0]  paddr,
  input  logic [dtsi_pkg::PDATA_W-1:0]  pwdata,
  output logic [dtsi_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dtsi_pkg::*;

  logic               scale_sel;
  logic [SCALE_W-1:0] scale_reg_q;
  logic               take;
  logic               fin_ready;
  logic               cfg_write;
  text_t              snap;
  err_e               fin_code;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign scale_sel = (paddr[2] == REG_IDX_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_reg_q <= SCALE_RESET;
    end else if (cfg_write && scale_sel) begin
      scale_reg_q <= pwdata[SCALE_W-1:0];
    end
  end

  assign prdata = scale_sel ? PDATA_W'(scale_reg_q) : '0;

  // input transfer
  assign stall_o = !fin_ready;
  assign take    = valid_i && fin_ready;

  dtsi_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_code_i),
    .has_char_i  (has_char_i),
    .last_char_i (last_char_i),
    .text_o      (snap)
  );

  dtsi_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .scale_i        (scale_reg_q),
    .snap_valid_i   (take && last_char_i),
    .snap_i         (snap),
    .ready_o        (fin_ready),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .scaled_value_o (scaled_value_o),
    .result_code_o  (fin_code)
  );

  assign result_code_o = fin_code;

endmodule

@@ design/dtsi_checker.sv @@
// port-level checker for the decimal text to scaled integer top, with its bind
// depends on dtsi_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "decimal_text_to_scaled_integer_top_macros.svh"

module dtsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic [63:0] scaled_value_o,
  input logic [2:0]  result_code_o
);
  import dtsi_pkg::*;

  `DTSI_ASSERT(a_result_held, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(scaled_value_o) && $stable(result_code_o), "stalled result changed")
  `DTSI_ASSERT(a_code_range, clk_i, rst_ni, valid_o |-> (result_code_o <= ERR_OVERFLOW), "result code out of range")
  `DTSI_ASSERT(a_error_zero, clk_i, rst_ni, valid_o && (result_code_o != ERR_NONE) |-> (scaled_value_o == '0), "value not zero on error")
  `DTSI_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !valid_o, "result valid during reset")

endmodule

bind decimal_text_to_scaled_integer_top dtsi_checker u_dtsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .scaled_value_o (scaled_value_o),
  .result_code_o  (result_code_o)
);
